@@ hw/rtl/nearest_point_manhattan_defines.svh @@
// Assertion macros for the nearest point search block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef NEAREST_POINT_MANHATTAN_DEFINES_SVH
`define NEAREST_POINT_MANHATTAN_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define NPM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted
`define NPM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ hw/rtl/npm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the nearest point search block.
// No dependencies.
package npm_pkg;

	localparam int SLOT_W   = 8;
	localparam int COUNT_W  = 9;
	localparam int NUMBER_W = 9;

	// input item kind codes
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// classified command from the front end
	typedef enum logic [1:0] {
		OP_DROP,
		OP_WRITE,
		OP_QUERY
	} npm_op_t;

	typedef struct packed {
		npm_op_t             op;
		logic [SLOT_W-1:0]   slot;
	} npm_cmd_t;

	// scan engine states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} npm_state_t;

endpackage

@@ hw/rtl/npm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module npm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/npm_fifo.sv @@
`timescale 1ns / 1ps
// Small register-based FIFO used between the front end, scan engine and output.
// No dependencies.
module npm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

@@ hw/rtl/npm_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input transactions, classifies them and queues commands.
// Depends on npm_pkg and npm_fifo.
module npm_front
	import npm_pkg::*;
#(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic                         kind,
	input  logic [SLOT_W-1:0]            slot,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	input  logic                         cmd_pop,
	output logic                         cmd_empty,
	output npm_cmd_t                     cmd_ctl,
	output logic [COORD_BITS-1:0]        cmd_x,
	output logic [COORD_BITS-1:0]        cmd_y
);

	localparam int CMD_W = $bits(npm_cmd_t) + 2 * COORD_BITS;

	npm_cmd_t         ctl_in;
	logic [CMD_W-1:0] cmd_wdata;
	logic [CMD_W-1:0] cmd_rdata;

	// classify: writes beyond the table are dropped here
	always_comb begin
		ctl_in.slot = slot;
		unique case (kind)
			KIND_QUERY: ctl_in.op = OP_QUERY;
			KIND_WRITE: ctl_in.op = (32'(slot) < 32'(MAX_POINTS)) ? OP_WRITE : OP_DROP;
			default:    ctl_in.op = OP_DROP;
		endcase
	end

	assign cmd_wdata = {ctl_in, coord_x, coord_y};

	npm_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cmd_wdata),
		.full   (full),
		.pop    (cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	assign {cmd_ctl, cmd_x, cmd_y} = cmd_rdata;

endmodule

@@ hw/rtl/npm_scan.sv @@
`timescale 1ns / 1ps
// Back end: executes table writes and runs the L1 nearest point scan.
// Depends on npm_pkg; drives the point RAM and the result queue.
module npm_scan
	import npm_pkg::*;
#(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 16
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic [COUNT_W-1:0]                          point_count,
	input  logic                                        cmd_empty,
	input  npm_cmd_t                                    cmd_ctl,
	input  logic [COORD_BITS-1:0]                       cmd_x,
	input  logic [COORD_BITS-1:0]                       cmd_y,
	output logic                                        cmd_pop,
	output logic                                        ram_we,
	output logic [(MAX_POINTS > 1 ? $clog2(MAX_POINTS) : 1)-1:0] ram_addr,
	output logic [2*COORD_BITS-1:0]                     ram_wdata,
	input  logic [2*COORD_BITS-1:0]                     ram_rdata,
	input  logic                                        res_full,
	output logic                                        res_push,
	output logic [NUMBER_W-1:0]                         res_number,
	output logic [COORD_BITS-1:0]                       res_x,
	output logic [COORD_BITS-1:0]                       res_y
);

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = AW + 1;
	localparam int DW    = COORD_BITS + 2;

	npm_state_t state_q, state_d;

	logic [CNT_W-1:0]             cnt_q;
	logic [CNT_W-1:0]             n_pts;
	logic [31:0]                  pc_ext;
	logic                         last_issue;
	logic                         issue;
	logic                         start_query;
	logic signed [COORD_BITS-1:0] qx_q, qy_q;

	// read pipeline
	logic                         valid_s1, last_s1;
	logic [AW-1:0]                idx_s1;
	logic                         valid_s2, last_s2;
	logic [AW-1:0]                idx_s2;
	logic [DW-1:0]                dist_s2;
	logic [COORD_BITS-1:0]        px_s2, py_s2;

	// running best
	logic                         have_q;
	logic [DW-1:0]                best_d_q;
	logic [AW-1:0]                best_idx_q;
	logic [COORD_BITS-1:0]        best_x_q, best_y_q;

	// distance datapath
	logic signed [COORD_BITS-1:0] px, py;
	logic signed [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS:0]          adx, ady;
	logic [DW-1:0]                l1_span;

	// effective count, saturated to the table size
	assign pc_ext     = 32'(point_count);
	assign n_pts      = (pc_ext > 32'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : CNT_W'(pc_ext);
	assign last_issue = (cnt_q == n_pts - 1'b1);

	assign ram_wdata = {cmd_x, cmd_y};

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and control
	always_comb begin
		state_d     = state_q;
		cmd_pop     = 1'b0;
		ram_we      = 1'b0;
		ram_addr    = cnt_q[AW-1:0];
		res_push    = 1'b0;
		issue       = 1'b0;
		start_query = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					cmd_pop = 1'b1;
					unique case (cmd_ctl.op)
						OP_WRITE: begin
							ram_we   = 1'b1;
							ram_addr = AW'(cmd_ctl.slot);
						end
						OP_QUERY: begin
							start_query = 1'b1;
							state_d     = (n_pts == '0) ? ST_DONE : ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_SCAN: begin
				issue = 1'b1;
				if (last_issue) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (valid_s2 && last_s2) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// |qx-px| + |qy-py| on the registered RAM read
	assign px      = ram_rdata[2*COORD_BITS-1:COORD_BITS];
	assign py      = ram_rdata[COORD_BITS-1:0];
	assign dx      = {qx_q[COORD_BITS-1], qx_q} - {px[COORD_BITS-1], px};
	assign dy      = {qy_q[COORD_BITS-1], qy_q} - {py[COORD_BITS-1], py};
	assign adx     = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
	assign ady     = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
	assign l1_span = DW'(adx) + DW'(ady);

	// pipeline valid bits and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			have_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= issue;
			valid_s2 <= valid_s1;
			if (start_query) begin
				cnt_q  <= '0;
				have_q <= 1'b0;
			end else begin
				if (issue) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (valid_s2) begin
					have_q <= 1'b1;
				end
			end
		end
	end

	// payload: query latch, pipeline data, best candidate
	always_ff @(posedge clk) begin
		last_s1 <= last_issue;
		idx_s1  <= cnt_q[AW-1:0];
		last_s2 <= last_s1;
		idx_s2  <= idx_s1;
		dist_s2 <= l1_span;
		px_s2   <= px;
		py_s2   <= py;
		if (start_query) begin
			qx_q       <= cmd_x;
			qy_q       <= cmd_y;
			best_idx_q <= '0;
			best_x_q   <= '0;
			best_y_q   <= '0;
		end else if (valid_s2 && (!have_q || dist_s2 < best_d_q)) begin
			// strict compare keeps the lowest slot on ties
			best_d_q   <= dist_s2;
			best_idx_q <= idx_s2;
			best_x_q   <= px_s2;
			best_y_q   <= py_s2;
		end
	end

	assign res_number = NUMBER_W'(best_idx_q) + NUMBER_W'(1);
	assign res_x      = best_x_q;
	assign res_y      = best_y_q;

endmodule

@@ hw/rtl/nearest_point_manhattan.sv @@
`timescale 1ns / 1ps
// Channel   | handshake          | payload
// ----------+--------------------+-----------------------------------------
// input     | push / full        | kind, slot, coord_x, coord_y
// result    | pop / empty        | point_number, point_x, point_y
// config    | point_count_we     | point_count
//
// A write transaction retires in the scan engine straight from the idle state.
// A query makes one RAM read per stored point, point_count capped at MAX_POINTS
// giving the number of points (none with an empty table); the reads are set by
// the single port of the point RAM.
// A two-entry command queue and a two-entry result queue decouple both sides.
// Reset clears the queues, the scan state and point_count; the point table
// holds no defined contents until written.
`include "nearest_point_manhattan_defines.svh"
module nearest_point_manhattan
	import npm_pkg::*;
#(
	parameter int MAX_POINTS = 256,
	parameter int COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         point_count_we,
	input  logic [COUNT_W-1:0]           point_count,
	input  logic                         push,
	output logic                         full,
	input  logic                         kind,
	input  logic [SLOT_W-1:0]            slot,
	input  logic signed [COORD_BITS-1:0] coord_x,
	input  logic signed [COORD_BITS-1:0] coord_y,
	output logic                         empty,
	input  logic                         pop,
	output logic [NUMBER_W-1:0]          point_number,
	output logic signed [COORD_BITS-1:0] point_x,
	output logic signed [COORD_BITS-1:0] point_y
);

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int RES_W = NUMBER_W + 2 * COORD_BITS;

	logic [COUNT_W-1:0]      point_count_q;
	logic                    cmd_pop, cmd_empty;
	npm_cmd_t                cmd_ctl;
	logic [COORD_BITS-1:0]   cmd_x, cmd_y;
	logic                    ram_we;
	logic [AW-1:0]           ram_addr;
	logic [2*COORD_BITS-1:0] ram_wdata, ram_rdata;
	logic                    res_push, res_full;
	logic [NUMBER_W-1:0]     res_number;
	logic [COORD_BITS-1:0]   res_x, res_y;
	logic [RES_W-1:0]        res_rdata;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
		end else if (point_count_we) begin
			point_count_q <= point_count;
		end
	end

	npm_front #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.kind      (kind),
		.slot      (slot),
		.coord_x   (coord_x),
		.coord_y   (coord_y),
		.cmd_pop   (cmd_pop),
		.cmd_empty (cmd_empty),
		.cmd_ctl   (cmd_ctl),
		.cmd_x     (cmd_x),
		.cmd_y     (cmd_y)
	);

	npm_scan #(
		.MAX_POINTS (MAX_POINTS),
		.COORD_BITS (COORD_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.point_count (point_count_q),
		.cmd_empty   (cmd_empty),
		.cmd_ctl     (cmd_ctl),
		.cmd_x       (cmd_x),
		.cmd_y       (cmd_y),
		.cmd_pop     (cmd_pop),
		.ram_we      (ram_we),
		.ram_addr    (ram_addr),
		.ram_wdata   (ram_wdata),
		.ram_rdata   (ram_rdata),
		.res_full    (res_full),
		.res_push    (res_push),
		.res_number  (res_number),
		.res_x       (res_x),
		.res_y       (res_y)
	);

	// point table, x in the upper half
	npm_ram #(
		.WIDTH (2 * COORD_BITS),
		.DEPTH (MAX_POINTS)
	) u_point_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// result queue toward the consumer
	npm_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  ({res_number, res_x, res_y}),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rdata),
		.empty  (empty)
	);

	assign {point_number, point_x, point_y} = res_rdata;

	// the engine only hands over a result when the queue has room
	`NPM_ASSERT_IMP(a_res_push_room, clk, arst_n, res_push, !res_full)
	// commands are taken only when one is waiting
	`NPM_ASSERT_IMP(a_cmd_pop_valid, clk, arst_n, cmd_pop, !cmd_empty)
	// each query yields exactly one result, so pushes never come back to back
	`NPM_ASSERT_NXT(a_res_push_single, clk, arst_n, res_push, !res_push)

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for nearest_point_manhattan: directed and random point writes and queries.
// Depends on npm_pkg and the nearest_point_manhattan RTL.
module tb_top;
	import npm_pkg::*;

	localparam int MAX_POINTS    = 256;
	localparam int COORD_W       = 16;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_CYCLES  = 300;
	localparam int HOLD_CYCLES   = 80;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;

	typedef struct packed {
		logic [NUMBER_W-1:0]         number;
		logic signed [COORD_W-1:0]   x;
		logic signed [COORD_W-1:0]   y;
	} nearest_t;

	logic                         clk;
	logic                         arst_n;
	logic                         point_count_we;
	logic [COUNT_W-1:0]           point_count;
	logic                         push;
	logic                         full;
	logic                         kind;
	logic [SLOT_W-1:0]            slot;
	logic signed [COORD_W-1:0]    coord_x;
	logic signed [COORD_W-1:0]    coord_y;
	logic                         empty;
	logic                         pop;
	logic [NUMBER_W-1:0]          point_number;
	logic signed [COORD_W-1:0]    point_x;
	logic signed [COORD_W-1:0]    point_y;

	// predictor state: point map and scan length
	logic signed [COORD_W-1:0]    map_x [MAX_POINTS];
	logic signed [COORD_W-1:0]    map_y [MAX_POINTS];
	logic [COUNT_W-1:0]           count_reg;
	nearest_t                     nearest_q [$];

	int err_count;
	bit tx_quiet;
	bit rx_quiet;
	int hold_req;

	nearest_point_manhattan dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.point_count_we (point_count_we),
		.point_count    (point_count),
		.push           (push),
		.full           (full),
		.kind           (kind),
		.slot           (slot),
		.coord_x        (coord_x),
		.coord_y        (coord_y),
		.empty          (empty),
		.pop            (pop),
		.point_number   (point_number),
		.point_x        (point_x),
		.point_y        (point_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit, far above the slowest legal run
	initial begin
		#10_000_000;
		$display("tb_top failed");
		$finish;
	end

	// L1 nearest point over the first count_reg entries (capped at MAX_POINTS), first minimum wins
	function automatic nearest_t find_nearest(input logic signed [COORD_W-1:0] qx,
			input logic signed [COORD_W-1:0] qy);
		nearest_t best;
		int scan_len;
		int dx;
		int dy;
		int best_span;
		best.number = NUMBER_W'(1);
		best.x = '0;
		best.y = '0;
		best_span = 0;
		scan_len = (count_reg > MAX_POINTS) ? MAX_POINTS : int'(count_reg);
		for (int i = 0; i < scan_len; i++) begin
			dx = int'(qx) - int'(map_x[i]);
			dy = int'(qy) - int'(map_y[i]);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (i == 0 || dx + dy < best_span) begin
				best_span = dx + dy;
				best.number = NUMBER_W'(i + 1);
				best.x = map_x[i];
				best.y = map_y[i];
			end
		end
		return best;
	endfunction

	// mix of full range, clustered values (for ties) and extremes
	function automatic logic signed [COORD_W-1:0] draw_coord();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return COORD_W'($urandom_range(0, 16'hFFFF));
			4, 5, 6: return COORD_W'(int'($urandom_range(0, 16)) - 8);
			7: return $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
			default: return COORD_W'(int'($urandom_range(0, 255)) - 128);
		endcase
	endfunction

	// offer one transaction, update the predictor when it is taken
	task automatic send_item(input logic k, input logic [SLOT_W-1:0] s,
			input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		slot <= s;
		coord_x <= x;
		coord_y <= y;
		@(posedge clk);
		while (full) @(posedge clk);
		if (k == KIND_WRITE) begin
			map_x[s] = x;
			map_y[s] = y;
		end else begin
			nearest_q.push_back(find_nearest(x, y));
		end
	endtask

	// program point_count once the block has gone idle
	task automatic set_count(input int unsigned value);
		push <= 1'b0;
		while (nearest_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		point_count_we <= 1'b1;
		point_count <= value[COUNT_W-1:0];
		@(posedge clk);
		point_count_we <= 1'b0;
		count_reg = value[COUNT_W-1:0];
	endtask

	task automatic test_empty_table();
		set_count(0);
		send_item(KIND_QUERY, 8'hFF, COORD_MIN, COORD_MIN);
		send_item(KIND_QUERY, 8'h00, COORD_MAX, COORD_MAX);
		send_item(KIND_QUERY, 8'h5A, 16'sd0, 16'sd0);
	endtask

	task automatic test_extreme_points();
		send_item(KIND_WRITE, 8'd0, COORD_MIN, COORD_MIN);
		send_item(KIND_WRITE, 8'd1, COORD_MAX, COORD_MAX);
		send_item(KIND_WRITE, 8'd2, 16'sd0, 16'sd0);
		send_item(KIND_WRITE, 8'd3, COORD_MIN, COORD_MAX);
		send_item(KIND_WRITE, 8'd4, COORD_MAX, COORD_MIN);
		send_item(KIND_WRITE, 8'd255, 16'sd1, -16'sd1);
		set_count(5);
		send_item(KIND_QUERY, 8'd0, COORD_MAX, COORD_MAX);
		send_item(KIND_QUERY, 8'd255, COORD_MIN, COORD_MIN);
		send_item(KIND_QUERY, 8'd7, 16'sd0, 16'sd0);
		send_item(KIND_QUERY, 8'd3, COORD_MIN, COORD_MAX);
		send_item(KIND_QUERY, 8'd1, 16'sd100, -16'sd100);
	endtask

	// equal distances: the lowest slot must win
	task automatic test_ties();
		send_item(KIND_WRITE, 8'd5, 16'sd2, 16'sd0);
		send_item(KIND_WRITE, 8'd6, 16'sd0, 16'sd2);
		set_count(7);
		send_item(KIND_QUERY, 8'd0, 16'sd1, 16'sd1);
		send_item(KIND_QUERY, 8'd0, 16'sd2, 16'sd2);
	endtask

	// single point at one corner, query at the other: widest distance
	task automatic test_longest_distance();
		set_count(1);
		send_item(KIND_QUERY, 8'd0, COORD_MAX, COORD_MAX);
	endtask

	task automatic test_fill_table();
		for (int i = 0; i < MAX_POINTS; i++)
			send_item(KIND_WRITE, i[SLOT_W-1:0], draw_coord(), draw_coord());
	endtask

	// stall the result side long enough that the input side reports full
	task automatic test_backpressure();
		set_count(8);
		tx_quiet = 1'b1;
		hold_req = HOLD_CYCLES;
		for (int i = 0; i < 12; i++)
			send_item(KIND_QUERY, SLOT_W'($urandom_range(0, 255)), draw_coord(),
				draw_coord());
		tx_quiet = 1'b0;
	endtask

	// phases at several scan lengths, saturating ones included
	task automatic test_random_phases();
		int unsigned counts [12];
		int n_items;
		counts = '{256, 511, 1, 2, 16, 300, 3, 64, 0, 5, 128, 0};
		counts[11] = $urandom_range(1, 40);
		foreach (counts[p]) begin
			set_count(counts[p]);
			tx_quiet = ($urandom_range(0, 3) == 0);
			rx_quiet = ($urandom_range(0, 3) == 0);
			n_items = (counts[p] > 64) ? 10 : 30;
			for (int i = 0; i < n_items; i++) begin
				if ($urandom_range(0, 9) < 6)
					send_item(KIND_QUERY, SLOT_W'($urandom_range(0, 255)), draw_coord(),
						draw_coord());
				else
					send_item(KIND_WRITE, SLOT_W'($urandom_range(0, 255)), draw_coord(),
						draw_coord());
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// result side: random pop gaps, plus one long hold on request
	initial begin : result_drain
		int gap;
		pop <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			gap = rx_quiet ? 0 : $urandom_range(0, 4);
			if (hold_req > 0) begin
				gap = hold_req;
				hold_req = 0;
			end
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	// compare each popped transaction with the oldest prediction
	always @(posedge clk) begin : result_check
		nearest_t want;
		if (arst_n && pop && !empty) begin
			if (nearest_q.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual number %0d (%0d, %0d)",
					$time, point_number, point_x, point_y);
				err_count++;
			end else begin
				want = nearest_q.pop_front();
				if (point_number !== want.number) begin
					$display("%0t: point_number mismatch: expected %0d, actual %0d",
						$time, want.number, point_number);
					err_count++;
				end
				if (point_x !== want.x) begin
					$display("%0t: point_x mismatch: expected %0d, actual %0d",
						$time, want.x, point_x);
					err_count++;
				end
				if (point_y !== want.y) begin
					$display("%0t: point_y mismatch: expected %0d, actual %0d",
						$time, want.y, point_y);
					err_count++;
				end
			end
		end
	end

	initial begin
		err_count = 0;
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
		hold_req = 0;
		count_reg = '0;
		arst_n <= 1'b0;
		point_count_we <= 1'b0;
		point_count <= '0;
		push <= 1'b0;
		kind <= KIND_WRITE;
		slot <= '0;
		coord_x <= '0;
		coord_y <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_extreme_points();
		test_ties();
		test_longest_distance();
		test_fill_table();
		test_backpressure();
		test_random_phases();

		// let every outstanding query come back, then watch for strays
		push <= 1'b0;
		while (nearest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
